[rtl/core/pressure_sensor_compensation_macros.svh]
// Assertion macros for the pressure sensor compensation block.
// No dependencies; included by the files that carry assertions.
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define PSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/psc_pkg.sv]
// Types, constants and helpers for the pressure sensor compensation block.
// No dependencies; used by the top level and its checker.
`default_nettype none

package psc_pkg;

   localparam int RAW_W    = 24;
   localparam int COEFF_W  = 16;
   localparam int SURF_W   = 23;
   localparam int CSR_W    = 23;
   localparam int TEMP_W   = 19;
   localparam int PRESS_W  = 24;
   localparam int DEPTH_W  = 22;
   localparam int WIDE_W   = 60;

   localparam int NUM_STAGES = 10;

   localparam int TEMP_SHIFT  = 23;
   localparam int OFF_SHIFT   = 7;
   localparam int SENS_SHIFT  = 8;
   localparam int PROD_SHIFT  = 21;
   localparam int PRESS_SHIFT = 13;
   localparam int DEPTH_SHIFT = 16;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

   localparam logic [SURF_W-1:0]  SURF_RESET  = 23'd101300;
   localparam logic [COEFF_W-1:0] SCALE_RESET = 16'd6519;

   typedef logic        [RAW_W-1:0]   raw_type;
   typedef logic        [COEFF_W-1:0] coeff_type;
   typedef logic        [SURF_W-1:0]  surf_type;
   typedef logic        [CSR_W-1:0]   csr_data_type;
   typedef logic signed [TEMP_W-1:0]  temp_type;
   typedef logic signed [PRESS_W-1:0] press_type;
   typedef logic signed [DEPTH_W-1:0] depth_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   typedef enum logic [2:0] {
      CSR_C1    = 3'd0,
      CSR_C2    = 3'd1,
      CSR_C3    = 3'd2,
      CSR_C4    = 3'd3,
      CSR_C5    = 3'd4,
      CSR_C6    = 3'd5,
      CSR_SURF  = 3'd6,
      CSR_SCALE = 3'd7
   } csr_index_type;

   // Arithmetic shift right that rounds toward zero.
   function automatic wide_type trunc_shift(input wide_type x, input logic [5:0] k);
      wide_type bias;
      bias = x[WIDE_W-1] ? ((wide_type'(1) <<< k) - wide_type'(1)) : '0;
      return (x + bias) >>> k;
   endfunction

endpackage

`default_nettype wire

[rtl/core/pressure_sensor_compensation.sv]
// Pressure sensor first-order compensation: top level, ten-stage pipeline.
// Depends on psc_pkg.
`default_nettype none
// Usage:
//  - req_ channel carries one raw pressure / raw temperature pair per beat;
//    a beat is taken when req_valid is high and req_stall is low.
//  - rsp_ channel returns temperature, pressure and depth, one beat per
//    request beat, in order; held while rsp_stall is high.
//  - csr_ port writes calibration, surface pressure and depth scale on any
//    edge with csr_write high and reset low; write it only while the pipeline is empty.
//  - A request beat passes through the ten register stages in order to
//    rsp_valid. One beat per cycle is taken while req_stall is low; each
//    stage holds one step of the arithmetic: products, wide adds or shifts.
//  - Each stage only moves when the stage after it is empty or moving, so
//    bubbles are squeezed out; req_stall rises only once every stage holds
//    a beat and the output is stalled.
//  - Synchronous reset empties the pipeline and loads the register reset
//    values (coefficients zero, surface pressure 101300, scale 6519).
module pressure_sensor_compensation (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  psc_pkg::raw_type        req_raw_pressure,
   input  psc_pkg::raw_type        req_raw_temperature,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output psc_pkg::temp_type       rsp_temperature_centi,
   output psc_pkg::press_type      rsp_pressure_value,
   output psc_pkg::depth_type      rsp_depth_mm,
   input  wire                     csr_write,
   input  psc_pkg::csr_index_type  csr_index,
   input  psc_pkg::csr_data_type   csr_wdata
);
   import psc_pkg::*;

   coeff_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, scale_ff;
   surf_type  surf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff    <= '0;
         c2_ff    <= '0;
         c3_ff    <= '0;
         c4_ff    <= '0;
         c5_ff    <= '0;
         c6_ff    <= '0;
         surf_ff  <= SURF_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_C1:    c1_ff    <= csr_wdata[COEFF_W-1:0];
            CSR_C2:    c2_ff    <= csr_wdata[COEFF_W-1:0];
            CSR_C3:    c3_ff    <= csr_wdata[COEFF_W-1:0];
            CSR_C4:    c4_ff    <= csr_wdata[COEFF_W-1:0];
            CSR_C5:    c5_ff    <= csr_wdata[COEFF_W-1:0];
            CSR_C6:    c6_ff    <= csr_wdata[COEFF_W-1:0];
            CSR_SURF:  surf_ff  <= csr_wdata[SURF_W-1:0];
            CSR_SCALE: scale_ff <= csr_wdata[COEFF_W-1:0];
            default:   ;
         endcase
      end
   end

   // ---------------- valid / flow control ----------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in = {vld_ff[NUM_STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // ---------------- stage 0: dT ----------------
   logic signed [24:0] s0_dt_in, s0_dt_ff;
   raw_type            s0_d1_ff;

   assign s0_dt_in = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, c5_ff, 8'h00});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_dt_ff <= s0_dt_in;
         s0_d1_ff <= req_raw_pressure;
      end
   end

   // ---------------- stage 1: dT products ----------------
   logic signed [41:0] s1_prod6_in, s1_prod4_in, s1_prod3_in;
   logic signed [41:0] s1_prod6_ff, s1_prod4_ff, s1_prod3_ff;
   raw_type            s1_d1_ff;

   assign s1_prod6_in = s0_dt_ff * $signed({1'b0, c6_ff});
   assign s1_prod4_in = s0_dt_ff * $signed({1'b0, c4_ff});
   assign s1_prod3_in = s0_dt_ff * $signed({1'b0, c3_ff});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_prod6_ff <= s1_prod6_in;
         s1_prod4_ff <= s1_prod4_in;
         s1_prod3_ff <= s1_prod3_in;
         s1_d1_ff    <= s0_d1_ff;
      end
   end

   // ---------------- stage 2: TEMP, OFF, SENS ----------------
   wide_type           s2_t6, s2_t4, s2_t3;
   temp_type           s2_temp_in, s2_temp_ff;
   logic signed [35:0] s2_off_in, s2_off_ff;
   logic signed [34:0] s2_sens_in, s2_sens_ff;
   raw_type            s2_d1_ff;

   always_comb begin
      s2_t6      = trunc_shift(WIDE_W'(s1_prod6_ff), 6'(TEMP_SHIFT));
      s2_t4      = trunc_shift(WIDE_W'(s1_prod4_ff), 6'(OFF_SHIFT));
      s2_t3      = trunc_shift(WIDE_W'(s1_prod3_ff), 6'(SENS_SHIFT));
      s2_temp_in = TEMP_W'(s2_t6) + TEMP_BASE;
      s2_off_in  = $signed({4'b0, c2_ff, 16'h0000}) + 36'(s2_t4);
      s2_sens_in = $signed({4'b0, c1_ff, 15'h0000}) + 35'(s2_t3);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_temp_ff <= s2_temp_in;
         s2_off_ff  <= s2_off_in;
         s2_sens_ff <= s2_sens_in;
         s2_d1_ff   <= s1_d1_ff;
      end
   end

   // ---------------- stage 3: D1 * SENS partial products ----------------
   // SENS split into an unsigned low half and a signed high half.
   logic signed [42:0] s3_pp_lo_in, s3_pp_hi_in, s3_pp_lo_ff, s3_pp_hi_ff;
   logic signed [35:0] s3_off_ff;
   temp_type           s3_temp_ff;

   assign s3_pp_lo_in = $signed({1'b0, s2_d1_ff}) * $signed({1'b0, s2_sens_ff[16:0]});
   assign s3_pp_hi_in = $signed({1'b0, s2_d1_ff}) * $signed(s2_sens_ff[34:17]);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_pp_lo_ff <= s3_pp_lo_in;
         s3_pp_hi_ff <= s3_pp_hi_in;
         s3_off_ff   <= s2_off_ff;
         s3_temp_ff  <= s2_temp_ff;
      end
   end

   // ---------------- stage 4: combine partial products ----------------
   wide_type           s4_full_in, s4_full_ff;
   logic signed [35:0] s4_off_ff;
   temp_type           s4_temp_ff;

   assign s4_full_in = (WIDE_W'(s3_pp_hi_ff) <<< 17) + WIDE_W'(s3_pp_lo_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_full_ff <= s4_full_in;
         s4_off_ff  <= s3_off_ff;
         s4_temp_ff <= s3_temp_ff;
      end
   end

   // ---------------- stage 5: D1*SENS / 2^21 ----------------
   logic signed [39:0] s5_t21_in, s5_t21_ff;
   logic signed [35:0] s5_off_ff;
   temp_type           s5_temp_ff;

   assign s5_t21_in = 40'(trunc_shift(s4_full_ff, 6'(PROD_SHIFT)));

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_t21_ff  <= s5_t21_in;
         s5_off_ff  <= s4_off_ff;
         s5_temp_ff <= s4_temp_ff;
      end
   end

   // ---------------- stage 6: minus OFF ----------------
   logic signed [39:0] s6_q_in, s6_q_ff;
   temp_type           s6_temp_ff;

   assign s6_q_in = s5_t21_ff - 40'(s5_off_ff);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_q_ff    <= s6_q_in;
         s6_temp_ff <= s5_temp_ff;
      end
   end

   // ---------------- stage 7: P = q / 2^13, saturated ----------------
   logic signed [39:0] s7_tq;
   press_type          s7_p_in, s7_p_ff;
   temp_type           s7_temp_ff;

   always_comb begin
      s7_tq = 40'(trunc_shift(WIDE_W'(s6_q_ff), 6'(PRESS_SHIFT)));
      if (!((&s7_tq[39:PRESS_W-1]) || !(|s7_tq[39:PRESS_W-1]))) begin
         s7_p_in = s7_tq[39] ? {1'b1, {(PRESS_W-1){1'b0}}} : {1'b0, {(PRESS_W-1){1'b1}}};
      end else begin
         s7_p_in = s7_tq[PRESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_p_ff    <= s7_p_in;
         s7_temp_ff <= s6_temp_ff;
      end
   end

   // ---------------- stage 8: (P - surface) * scale ----------------
   logic signed [24:0] s8_diff;
   logic signed [41:0] s8_dprod_in, s8_dprod_ff;
   press_type          s8_p_ff;
   temp_type           s8_temp_ff;

   always_comb begin
      s8_diff     = $signed({s7_p_ff[PRESS_W-1], s7_p_ff}) - $signed({2'b00, surf_ff});
      s8_dprod_in = s8_diff * $signed({1'b0, scale_ff});
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s8_dprod_ff <= s8_dprod_in;
         s8_p_ff     <= s7_p_ff;
         s8_temp_ff  <= s7_temp_ff;
      end
   end

   // ---------------- stage 9: depth / 2^16, saturated; output ----------------
   logic signed [41:0] s9_td;
   depth_type          s9_depth_in, s9_depth_ff;
   press_type          s9_p_ff;
   temp_type           s9_temp_ff;

   always_comb begin
      s9_td = 42'(trunc_shift(WIDE_W'(s8_dprod_ff), 6'(DEPTH_SHIFT)));
      if (!((&s9_td[41:DEPTH_W-1]) || !(|s9_td[41:DEPTH_W-1]))) begin
         s9_depth_in = s9_td[41] ? {1'b1, {(DEPTH_W-1){1'b0}}} : {1'b0, {(DEPTH_W-1){1'b1}}};
      end else begin
         s9_depth_in = s9_td[DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         s9_depth_ff <= s9_depth_in;
         s9_p_ff     <= s8_p_ff;
         s9_temp_ff  <= s8_temp_ff;
      end
   end

   assign rsp_temperature_centi = s9_temp_ff;
   assign rsp_pressure_value    = s9_p_ff;
   assign rsp_depth_mm          = s9_depth_ff;

endmodule

`default_nettype wire

[rtl/core/psc_checker.sv]
// Port-level checker for pressure_sensor_compensation, with its bind.
// Depends on psc_pkg and pressure_sensor_compensation_macros.svh.
`default_nettype none
`include "pressure_sensor_compensation_macros.svh"

module psc_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_stall,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input psc_pkg::temp_type       rsp_temperature_centi,
   input psc_pkg::press_type      rsp_pressure_value,
   input psc_pkg::depth_type      rsp_depth_mm
);
   import psc_pkg::*;

   logic                              rsp_waits;
   logic                              pipe_idle;
   logic [TEMP_W+PRESS_W+DEPTH_W:0]   rsp_beat;

   assign rsp_waits = rsp_valid && rsp_stall;
   assign pipe_idle = !rsp_valid && !req_stall;
   assign rsp_beat  = {rsp_valid, rsp_temperature_centi, rsp_pressure_value, rsp_depth_mm};

   // stalled result beat must hold
   `PSC_ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_waits, $stable(rsp_beat), "stalled beat changed")

   // reset empties the pipeline
   `PSC_ASSERT_NEXT(reset_empty_chk, clock, 1'b0, reset, pipe_idle, "not empty after reset")

   // back-pressure only propagates from a stalled output beat
   `PSC_ASSERT_IMPL(stall_cause_chk, clock, reset, req_stall, rsp_waits, "stray input stall")

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (.*);

`default_nettype wire
